FILE: hw/rtl/bb3_pkg.sv
// Shared types, constants and helper functions of the 3x3 box blur.
// Used by the channel interfaces and by every module of the block but bb3_ram.
package bb3_pkg;

    // Field widths of the stream and the configuration port.
    localparam int PIX_W          = 8;
    localparam int RGB_W          = 3 * PIX_W;
    localparam int FRAME_WIDTH_W  = 11;
    localparam int FRAME_HEIGHT_W = 16;
    localparam int CFG_DATA_W     = 16;
    localparam int CFG_IDX_W      = 1;

    // Default depth of the line store, in pixels.
    localparam int MAX_WIDTH_DEF = 1024;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    // A sum of nine channel values plus the rounding half fits in 12 bits.
    localparam int SUM_W       = 12;
    localparam int RECIP_W     = 15;
    localparam int RECIP_SHIFT = 16;
    localparam int PROD_W      = SUM_W + RECIP_W;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } t_rgb;

    // Which window rows and columns fall outside the frame.
    typedef struct packed {
        logic top;
        logic bottom;
        logic left;
        logic right;
    } t_edges;

    // Item held after the input register, while the line store is read.
    typedef struct packed {
        logic   has_result;
        t_edges edges;
        logic   last;
        t_rgb   pixel;
    } t_stage_a;

    // Item held in the window stage: the full 3x3 neighborhood.
    typedef struct packed {
        t_edges               edges;
        logic                 last;
        t_rgb [2:0][2:0]      cells;
    } t_stage_b;

    // Number of in-frame neighbors: corner, edge or interior.
    typedef enum logic [1:0] {
        DIV_BY_4 = 2'd0,
        DIV_BY_6 = 2'd1,
        DIV_BY_9 = 2'd2
    } t_div_sel;

    // Reciprocal of the divisor scaled by 2**RECIP_SHIFT, rounded up. The
    // error term stays small enough that the quotient is exact for every
    // sum this block can produce.
    function automatic logic [RECIP_W-1:0] div_recip(t_div_sel sel);
        logic [RECIP_W-1:0] recip;
        unique case (sel)
            DIV_BY_4: recip = RECIP_W'(16384);
            DIV_BY_6: recip = RECIP_W'(10923);
            DIV_BY_9: recip = RECIP_W'(7282);
            default:  recip = RECIP_W'(7282);
        endcase
        return recip;
    endfunction

    // Half of the divisor, added before the divide to round to nearest.
    function automatic logic [SUM_W-1:0] div_half(t_div_sel sel);
        logic [SUM_W-1:0] half;
        unique case (sel)
            DIV_BY_4: half = SUM_W'(2);
            DIV_BY_6: half = SUM_W'(3);
            DIV_BY_9: half = SUM_W'(4);
            default:  half = SUM_W'(4);
        endcase
        return half;
    endfunction

endpackage

FILE: hw/rtl/bb3_pix_if.sv
// Input pixel channel of the box blur: valid/ready handshake and payload.
// Depends on bb3_pkg for the field widths.
interface bb3_pix_if;
    logic                      valid;
    logic                      ready;
    logic                      action;
    logic [bb3_pkg::PIX_W-1:0] red;
    logic [bb3_pkg::PIX_W-1:0] green;
    logic [bb3_pkg::PIX_W-1:0] blue;

    modport source (output valid, action, red, green, blue, input ready);
    modport sink   (input valid, action, red, green, blue, output ready);
endinterface

FILE: hw/rtl/bb3_blur_if.sv
// Output channel of the box blur: valid/ready handshake and blurred pixel.
// Depends on bb3_pkg for the field widths.
interface bb3_blur_if;
    logic                      valid;
    logic                      ready;
    logic [bb3_pkg::PIX_W-1:0] blur_red;
    logic [bb3_pkg::PIX_W-1:0] blur_green;
    logic [bb3_pkg::PIX_W-1:0] blur_blue;
    logic                      frame_last;

    modport source (output valid, blur_red, blur_green, blur_blue, frame_last, input ready);
    modport sink   (input valid, blur_red, blur_green, blur_blue, frame_last, output ready);
endinterface

FILE: hw/rtl/bb3_cfg_if.sv
// Configuration write channel of the box blur: register index and data.
// Depends on bb3_pkg for the field widths.
interface bb3_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [bb3_pkg::CFG_IDX_W-1:0]  index;
    logic [bb3_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/bb3_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Stand-alone; no package needed.
module bb3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hw/rtl/bb3_ctrl.sv
// Input stage of the box blur: frame size registers, stream position
// counters, the input register and the line store read. Uses bb3_pkg.
module bb3_ctrl #(
    parameter int MAX_WIDTH = bb3_pkg::MAX_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    bb3_pix_if.sink                      i_pix,
    bb3_cfg_if.sink                      i_cfg,
    input  logic                         i_b_ready,
    output logic                         o_a_valid,
    output bb3_pkg::t_stage_a            o_a_item,
    output logic [$clog2(MAX_WIDTH)-1:0] o_a_col,
    output logic                         o_rd_en,
    output logic [$clog2(MAX_WIDTH)-1:0] o_rd_addr
);
    import bb3_pkg::*;

    localparam int CB = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = FRAME_HEIGHT_W;
    localparam int RW = FRAME_HEIGHT_W + 1;

    logic [WW-1:0] r_eff_w;
    logic [HW-1:0] r_eff_h;
    logic [CB-1:0] r_in_col;
    logic [RW-1:0] r_in_row;
    logic [CB-1:0] r_out_col;
    logic [HW-1:0] r_out_row;
    logic          r_a_valid;
    t_stage_a      r_a_item;
    logic [CB-1:0] r_a_col;

    logic [WW-1:0] n_cfg_w;
    logic [HW-1:0] n_cfg_h;
    logic [CB-1:0] n_in_col;
    logic [RW-1:0] n_in_row;
    logic [CB-1:0] n_out_col;
    logic [HW-1:0] n_out_row;
    t_stage_a      n_a_item;

    logic [FRAME_WIDTH_W-1:0] cfg_w;
    logic [WW-1:0]            in_col_inc;
    logic [WW-1:0]            out_col_inc;
    logic                     cfg_fire;
    logic                     pix_fire;
    logic                     drain;
    logic                     skip;
    logic                     push;
    logic                     primed;
    logic                     row_end;
    t_edges                   edges;
    logic                     last;

    // Sizes are clamped when written, so the datapath sees legal values only.
    assign cfg_fire  = i_cfg.valid && i_cfg.ready;
    assign i_cfg.ready = 1'b1;
    assign cfg_w     = i_cfg.data[FRAME_WIDTH_W-1:0];

    always_comb begin
        priority if (cfg_w < FRAME_WIDTH_W'(2)) begin
            n_cfg_w = WW'(2);
        end else if (32'(cfg_w) > 32'(MAX_WIDTH)) begin
            n_cfg_w = WW'(MAX_WIDTH);
        end else begin
            n_cfg_w = WW'(cfg_w);
        end
        n_cfg_h = (i_cfg.data[HW-1:0] < HW'(2)) ? HW'(2) : i_cfg.data[HW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eff_w <= WW'(2);
            r_eff_h <= HW'(2);
        end else if (cfg_fire) begin
            unique case (i_cfg.index)
                CFG_FRAME_WIDTH:  r_eff_w <= n_cfg_w;
                CFG_FRAME_HEIGHT: r_eff_h <= n_cfg_h;
                default:          r_eff_h <= r_eff_h;
            endcase
        end
    end

    // Accept an item whenever the input register is free or moving on.
    assign i_pix.ready = !r_a_valid || i_b_ready;
    assign pix_fire    = i_pix.valid && i_pix.ready;

    // Once all rows are in, every item drains; a flush before that is dropped.
    assign drain = r_in_row >= RW'(r_eff_h);
    assign skip  = i_pix.action && !drain;
    assign push  = pix_fire && !skip;

    // Stream and result positions, and the edge flags of this result.
    always_comb begin
        in_col_inc  = WW'(r_in_col) + WW'(1);
        out_col_inc = WW'(r_out_col) + WW'(1);
        row_end     = in_col_inc >= r_eff_w;
        primed      = (r_in_row >= RW'(2)) || ((r_in_row == RW'(1)) && (r_in_col != '0));

        edges.top    = r_out_row == '0;
        edges.bottom = (RW'(r_out_row) + RW'(1)) >= RW'(r_eff_h);
        edges.left   = r_out_col == '0;
        edges.right  = out_col_inc >= r_eff_w;
        last         = edges.right && edges.bottom;

        n_in_col  = row_end ? '0 : CB'(in_col_inc);
        n_in_row  = row_end ? (r_in_row + RW'(1)) : r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (primed) begin
            n_out_col = edges.right ? '0 : CB'(out_col_inc);
            n_out_row = edges.right ? (r_out_row + HW'(1)) : r_out_row;
        end
        // The final result of a frame restarts every position.
        if (primed && last) begin
            n_in_col  = '0;
            n_in_row  = '0;
            n_out_col = '0;
            n_out_row = '0;
        end

        n_a_item.has_result = primed;
        n_a_item.edges      = edges;
        n_a_item.last       = last;
        n_a_item.pixel      = drain ? '0 : t_rgb'({i_pix.red, i_pix.green, i_pix.blue});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_a_valid <= 1'b0;
        end else begin
            if (push) begin
                r_in_col  <= n_in_col;
                r_in_row  <= n_in_row;
                r_out_col <= n_out_col;
                r_out_row <= n_out_row;
            end
            if (push) begin
                r_a_valid <= 1'b1;
            end else if (i_b_ready) begin
                r_a_valid <= 1'b0;
            end
        end
    end

    // Input register payload.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_a_item <= n_a_item;
            r_a_col  <= r_in_col;
        end
    end

    // The line store is read as the item enters the input register.
    assign o_rd_en   = push;
    assign o_rd_addr = r_in_col;
    assign o_a_valid = r_a_valid;
    assign o_a_item  = r_a_item;
    assign o_a_col   = r_a_col;

endmodule

FILE: hw/rtl/bb3_window.sv
// Window stage of the box blur: line store write-back and the 3x3 window
// of pixels around the current result. Uses bb3_pkg.
module bb3_window #(
    parameter int MAX_WIDTH = bb3_pkg::MAX_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_a_valid,
    input  bb3_pkg::t_stage_a            i_a_item,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_a_col,
    input  logic [2*bb3_pkg::RGB_W-1:0]  i_rd_data,
    input  logic                         i_c_ready,
    output logic                         o_a_ready,
    output logic                         o_wr_en,
    output logic [$clog2(MAX_WIDTH)-1:0] o_wr_addr,
    output logic [2*bb3_pkg::RGB_W-1:0]  o_wr_data,
    output logic                         o_b_valid,
    output bb3_pkg::t_stage_b            o_b_item
);
    import bb3_pkg::*;

    logic     r_b_valid;
    t_stage_b r_b_item;
    logic     a_ready;
    logic     a_take;
    t_rgb     up_px;
    logic [RGB_W-1:0] lo_px;

    // Line store entry holds the two rows above: older in the upper half.
    assign up_px = t_rgb'(i_rd_data[2*RGB_W-1:RGB_W]);
    assign lo_px = i_rd_data[RGB_W-1:0];

    assign a_ready = !r_b_valid || i_c_ready;
    assign a_take  = i_a_valid && a_ready;

    // Each row of the column moves up one line store.
    assign o_wr_en   = a_take;
    assign o_wr_addr = i_a_col;
    assign o_wr_data = {lo_px, RGB_W'(i_a_item.pixel)};

    // Shift the window left and bring in the new column. Items that give
    // no result still shift the window but do not occupy this stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_b_item  <= '0;
        end else begin
            if (a_take) begin
                r_b_valid <= i_a_item.has_result;
                r_b_item.edges <= i_a_item.edges;
                r_b_item.last  <= i_a_item.last;
                for (int r = 0; r < 3; r++) begin
                    r_b_item.cells[r][0] <= r_b_item.cells[r][1];
                    r_b_item.cells[r][1] <= r_b_item.cells[r][2];
                end
                r_b_item.cells[0][2] <= up_px;
                r_b_item.cells[1][2] <= t_rgb'(lo_px);
                r_b_item.cells[2][2] <= i_a_item.pixel;
            end else if (i_c_ready) begin
                r_b_valid <= 1'b0;
            end
        end
    end

    assign o_a_ready = a_ready;
    assign o_b_valid = r_b_valid;
    assign o_b_item  = r_b_item;

endmodule

FILE: hw/rtl/bb3_mean.sv
// Averaging stages of the box blur: masked channel sums, then the rounded
// divide by a reciprocal multiply, into the output register. Uses bb3_pkg.
module bb3_mean (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_b_valid,
    input  bb3_pkg::t_stage_b i_b_item,
    output logic              o_b_ready,
    bb3_blur_if.source        o_blur
);
    import bb3_pkg::*;

    logic             r_c_valid;
    logic [SUM_W-1:0] r_c_x [3];
    t_div_sel         r_c_sel;
    logic             r_c_last;
    logic             r_d_valid;
    logic [PIX_W-1:0] r_d_q [3];
    logic             r_d_last;

    logic [SUM_W-1:0] n_c_x [3];
    t_div_sel         n_c_sel;
    logic [PIX_W-1:0] n_d_q [3];
    logic [PROD_W-1:0] prod [3];
    logic             c_ready;
    logic             d_ready;
    logic             b_take;
    logic             c_take;
    logic             use_cell;

    assign d_ready   = !r_d_valid || o_blur.ready;
    assign c_ready   = !r_c_valid || d_ready;
    assign b_take    = i_b_valid && c_ready;
    assign c_take    = r_c_valid && d_ready;
    assign o_b_ready = c_ready;

    // Sum the in-frame cells of each channel and pick the divisor.
    always_comb begin
        use_cell = 1'b0;
        for (int ch = 0; ch < 3; ch++) begin
            n_c_x[ch] = '0;
        end
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                use_cell = !(((r == 0) && i_b_item.edges.top) ||
                             ((r == 2) && i_b_item.edges.bottom) ||
                             ((c == 0) && i_b_item.edges.left) ||
                             ((c == 2) && i_b_item.edges.right));
                if (use_cell) begin
                    n_c_x[0] = n_c_x[0] + SUM_W'(i_b_item.cells[r][c].red);
                    n_c_x[1] = n_c_x[1] + SUM_W'(i_b_item.cells[r][c].green);
                    n_c_x[2] = n_c_x[2] + SUM_W'(i_b_item.cells[r][c].blue);
                end
            end
        end
        priority if ((i_b_item.edges.top || i_b_item.edges.bottom) &&
                     (i_b_item.edges.left || i_b_item.edges.right)) begin
            n_c_sel = DIV_BY_4;
        end else if (i_b_item.edges.top || i_b_item.edges.bottom ||
                     i_b_item.edges.left || i_b_item.edges.right) begin
            n_c_sel = DIV_BY_6;
        end else begin
            n_c_sel = DIV_BY_9;
        end
        for (int ch = 0; ch < 3; ch++) begin
            n_c_x[ch] = n_c_x[ch] + div_half(n_c_sel);
        end
    end

    // Divide by a constant: multiply by the scaled reciprocal and shift.
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            prod[ch]  = PROD_W'(r_c_x[ch]) * PROD_W'(div_recip(r_c_sel));
            n_d_q[ch] = prod[ch][RECIP_SHIFT +: PIX_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else begin
            if (b_take) begin
                r_c_valid <= 1'b1;
            end else if (d_ready) begin
                r_c_valid <= 1'b0;
            end
            if (c_take) begin
                r_d_valid <= 1'b1;
            end else if (o_blur.ready) begin
                r_d_valid <= 1'b0;
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (b_take) begin
            r_c_x    <= n_c_x;
            r_c_sel  <= n_c_sel;
            r_c_last <= i_b_item.last;
        end
        if (c_take) begin
            r_d_q    <= n_d_q;
            r_d_last <= r_c_last;
        end
    end

    assign o_blur.valid      = r_d_valid;
    assign o_blur.blur_red   = r_d_q[0];
    assign o_blur.blur_green = r_d_q[1];
    assign o_blur.blur_blue  = r_d_q[2];
    assign o_blur.frame_last = r_d_last;

endmodule

FILE: hw/rtl/box_blur_3x3_edge_average.sv
// 3x3 box blur of an RGB raster stream, averaging only in-frame neighbors.
// Depends on bb3_pkg, the three channel interfaces, bb3_ram, bb3_ctrl,
// bb3_window and bb3_mean.
//
// The block takes one item per clock and gives one blurred pixel per clock
// at full rate unless the output stalls; the line store, one memory with a
// read and a write port, serves one column each cycle, and each of the four
// pipeline stages holds one item. An item passes the window and sum stages
// to the output register. Results trail the input stream by frame_width+1
// positions: after the last pixel of a frame, send frame_width+1 flush items
// (action = 1) to drain it; the last result is marked frame_last and the next
// item starts a new frame. Flush items sent before all pixels of a frame are
// in are taken and dropped. Each pixel is the per-channel mean of its 4, 6 or
// 9 in-frame neighbors, rounded to nearest with halves up. Frame width is
// clamped to 2..MAX_WIDTH and height to at least 2; write the size registers
// only while the block is idle. No start-up pass is needed after reset.
module box_blur_3x3_edge_average #(
    parameter int MAX_WIDTH = bb3_pkg::MAX_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bb3_pix_if.sink    i_pix,
    bb3_cfg_if.sink    i_cfg,
    bb3_blur_if.source o_blur
);
    import bb3_pkg::*;

    localparam int CB = $clog2(MAX_WIDTH);

    logic             a_valid;
    t_stage_a         a_item;
    logic [CB-1:0]    a_col;
    logic             a_ready;
    logic             rd_en;
    logic [CB-1:0]    rd_addr;
    logic [2*RGB_W-1:0] rd_data;
    logic             wr_en;
    logic [CB-1:0]    wr_addr;
    logic [2*RGB_W-1:0] wr_data;
    logic             b_valid;
    t_stage_b         b_item;
    logic             b_ready;

    // Input register, position counters and size registers.
    bb3_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_pix     (i_pix),
        .i_cfg     (i_cfg),
        .i_b_ready (a_ready),
        .o_a_valid (a_valid),
        .o_a_item  (a_item),
        .o_a_col   (a_col),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr)
    );

    // Both previous rows share one store, one entry per column.
    bb3_ram #(
        .WIDTH (2 * RGB_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // 3x3 window.
    bb3_window #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_a_valid (a_valid),
        .i_a_item  (a_item),
        .i_a_col   (a_col),
        .i_rd_data (rd_data),
        .i_c_ready (b_ready),
        .o_a_ready (a_ready),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_b_valid (b_valid),
        .o_b_item  (b_item)
    );

    // Sums, divide and output register.
    bb3_mean u_mean (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_b_valid (b_valid),
        .i_b_item  (b_item),
        .o_b_ready (b_ready),
        .o_blur    (o_blur)
    );

endmodule
